// File: hw/rtl/pfa_pkg.sv
package pfa_pkg;

    // Field widths fixed by the item format
    localparam int SLOT_W   = 4;
    localparam int AMOUNT_W = 8;
    localparam int COUNT_W  = 5;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = 5;
    localparam int MAX_SLOTS = 16;

    // Configuration register indexes
    localparam logic CFG_FIT_MODE   = 1'b0;
    localparam logic CFG_PART_COUNT = 1'b1;

    // Item actions
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NEXT  = 2'd3
    } t_fit_mode;

    // Candidate record handed from cell to cell during a scan.
    // lo: first/best/worst candidate over the whole row.
    // hi: first candidate at or after the next-fit start slot.
    typedef struct packed {
        logic                lo_hit;
        logic [SLOT_W-1:0]   lo_slot;
        logic [AMOUNT_W-1:0] lo_size;
        logic                hi_hit;
        logic [SLOT_W-1:0]   hi_slot;
        logic [AMOUNT_W-1:0] hi_size;
    } t_cand;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        t_fit_mode           mode;
        logic [AMOUNT_W-1:0] need;
        logic [COUNT_W-1:0]  n_used;
        logic [SLOT_W-1:0]   start;
        logic                wr_en;
        logic [SLOT_W-1:0]   wr_slot;
        logic [AMOUNT_W-1:0] wr_data;
    } t_ctl;

endpackage

// File: hw/rtl/pfa_in_if.sv
interface pfa_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [pfa_pkg::SLOT_W-1:0]    slot;
    logic [pfa_pkg::AMOUNT_W-1:0]  amount;

    modport source (output valid, output action, output slot, output amount, input ready);
    modport sink   (input valid, input action, input slot, input amount, output ready);
endinterface

// File: hw/rtl/pfa_out_if.sv
interface pfa_out_if;
    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic [pfa_pkg::SLOT_W-1:0]    chosen_slot;
    logic [pfa_pkg::AMOUNT_W-1:0]  remaining;
    logic                          exact_fit;

    modport source (output valid, output granted, output chosen_slot, output remaining,
                    output exact_fit, input ready);
    modport sink   (input valid, input granted, input chosen_slot, input remaining,
                    input exact_fit, output ready);
endinterface

// File: hw/rtl/pfa_cell.sv
module pfa_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pfa_pkg::t_ctl  i_ctl,
    input  pfa_pkg::t_cand i_cand,
    output pfa_pkg::t_cand o_cand
);

    logic [pfa_pkg::AMOUNT_W-1:0] r_size;
    pfa_pkg::t_cand               r_cand;
    pfa_pkg::t_cand               n_cand;
    logic                         fits;
    logic                         at_start;

    // This slot can serve the request
    assign fits = (pfa_pkg::COUNT_W'(IDX) < i_ctl.n_used) && (r_size != '0)
                  && (r_size >= i_ctl.need);
    assign at_start = (pfa_pkg::SLOT_W'(IDX) >= i_ctl.start);

    // Fold this slot into the passing candidate
    always_comb begin
        n_cand = i_cand;
        case (i_ctl.mode)
            pfa_pkg::FIT_BEST: begin
                if (fits && (!i_cand.lo_hit || r_size < i_cand.lo_size)) begin
                    n_cand.lo_hit  = 1'b1;
                    n_cand.lo_slot = pfa_pkg::SLOT_W'(IDX);
                    n_cand.lo_size = r_size;
                end
            end
            pfa_pkg::FIT_WORST: begin
                if (fits && (!i_cand.lo_hit || r_size > i_cand.lo_size)) begin
                    n_cand.lo_hit  = 1'b1;
                    n_cand.lo_slot = pfa_pkg::SLOT_W'(IDX);
                    n_cand.lo_size = r_size;
                end
            end
            default: begin
                if (fits && !i_cand.lo_hit) begin
                    n_cand.lo_hit  = 1'b1;
                    n_cand.lo_slot = pfa_pkg::SLOT_W'(IDX);
                    n_cand.lo_size = r_size;
                end
            end
        endcase
        if (fits && at_start && !i_cand.hi_hit) begin
            n_cand.hi_hit  = 1'b1;
            n_cand.hi_slot = pfa_pkg::SLOT_W'(IDX);
            n_cand.hi_size = r_size;
        end
    end

    // Free size of this slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (i_ctl.wr_en && i_ctl.wr_slot == pfa_pkg::SLOT_W'(IDX)) begin
            r_size <= i_ctl.wr_data;
        end
    end

    // Candidate handed to the next cell
    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    assign o_cand = r_cand;

endmodule

// File: hw/rtl/partition_fit_allocator.sv
// Partition allocator with first, best, worst and next fit. The free sizes
// live in a row of cells, one per slot (min(SLOTS,16) cells). A load item
// writes one slot and its result is presented on the next cycle. A request
// item launches a candidate that moves one cell per clock down the row; its
// result is presented once the candidate has passed the whole cell row and
// the sequencer has gone from the scan state to the done state, where the
// winner is written back on the same edge that loads the result. One item
// is worked on at a time, and the input is held off while a result waits in
// the output register, so a new request is taken only after the last one has
// left the done state and the output register has room. Free sizes and the
// next-fit start reset to zero.
module partition_fit_allocator #(
    parameter int SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [pfa_pkg::CFG_W-1:0]   i_cfg_data,
    pfa_in_if.sink                      i_item,
    pfa_out_if.source                   o_result
);

    localparam int DEPTH = (SLOTS < pfa_pkg::MAX_SLOTS) ? SLOTS : pfa_pkg::MAX_SLOTS;
    localparam int CW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_cnt;
    pfa_pkg::t_fit_mode              r_mode;
    logic [pfa_pkg::COUNT_W-1:0]     r_count;
    logic [pfa_pkg::SLOT_W-1:0]      r_next_start;
    logic [pfa_pkg::AMOUNT_W-1:0]    r_need;

    logic                            r_o_valid;
    logic                            r_o_granted;
    logic [pfa_pkg::SLOT_W-1:0]      r_o_slot;
    logic [pfa_pkg::AMOUNT_W-1:0]    r_o_remaining;
    logic                            r_o_exact;

    pfa_pkg::t_ctl                   ctl;
    pfa_pkg::t_cand                  chain [DEPTH+1];
    logic [pfa_pkg::COUNT_W-1:0]     n_used;
    logic                            out_free;
    logic                            in_accept;
    logic                            is_load;
    logic                            pick_hit;
    logic [pfa_pkg::SLOT_W-1:0]      pick_slot;
    logic [pfa_pkg::AMOUNT_W-1:0]    pick_size;
    logic [pfa_pkg::AMOUNT_W-1:0]    pick_rem;
    logic                            finish;

    assign n_used = (r_count > pfa_pkg::COUNT_W'(DEPTH)) ? pfa_pkg::COUNT_W'(DEPTH) : r_count;

    assign out_free     = !r_o_valid || o_result.ready;
    assign i_item.ready = (r_state == S_IDLE) && out_free;
    assign in_accept    = i_item.valid && i_item.ready;
    assign is_load      = (i_item.action == pfa_pkg::ACT_LOAD);
    assign finish       = (r_state == S_DONE) && out_free;

    // Winner at the end of the row
    always_comb begin
        if (r_mode == pfa_pkg::FIT_NEXT && chain[DEPTH].hi_hit) begin
            pick_hit  = 1'b1;
            pick_slot = chain[DEPTH].hi_slot;
            pick_size = chain[DEPTH].hi_size;
        end else begin
            pick_hit  = chain[DEPTH].lo_hit;
            pick_slot = chain[DEPTH].lo_slot;
            pick_size = chain[DEPTH].lo_size;
        end
        pick_rem = pick_size - r_need;
    end

    // Broadcast control to the cells
    always_comb begin
        ctl.mode    = r_mode;
        ctl.need    = r_need;
        ctl.n_used  = n_used;
        ctl.start   = (pfa_pkg::COUNT_W'(r_next_start) < n_used) ? r_next_start : '0;
        ctl.wr_en   = 1'b0;
        ctl.wr_slot = pick_slot;
        ctl.wr_data = pick_rem;
        if (r_state == S_IDLE) begin
            ctl.wr_en   = in_accept && is_load;
            ctl.wr_slot = i_item.slot;
            ctl.wr_data = i_item.amount;
        end else if (finish) begin
            ctl.wr_en = pick_hit;
        end
    end

    // Row of slot cells
    assign chain[0] = '0;
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        pfa_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_cand  (chain[g]),
            .o_cand  (chain[g+1])
        );
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && !is_load) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == CW'(DEPTH - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Request amount held through the scan
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_need <= i_item.amount;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pfa_pkg::FIT_FIRST;
            r_count <= pfa_pkg::COUNT_W'(pfa_pkg::MAX_SLOTS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfa_pkg::CFG_FIT_MODE: begin
                    r_mode <= pfa_pkg::t_fit_mode'(i_cfg_data[pfa_pkg::MODE_W-1:0]);
                end
                pfa_pkg::CFG_PART_COUNT: r_count <= i_cfg_data[pfa_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Next-fit start follows the last next-fit grant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_start <= '0;
        end else if (finish && pick_hit && r_mode == pfa_pkg::FIT_NEXT) begin
            r_next_start <= pick_slot;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (in_accept && is_load) begin
            r_o_valid <= 1'b1;
        end else if (finish) begin
            r_o_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && is_load) begin
            r_o_granted   <= 1'b0;
            r_o_slot      <= '0;
            r_o_remaining <= '0;
            r_o_exact     <= 1'b0;
        end else if (finish) begin
            r_o_granted   <= pick_hit;
            r_o_slot      <= pick_hit ? pick_slot : '0;
            r_o_remaining <= pick_hit ? pick_rem : '0;
            r_o_exact     <= pick_hit && (pick_rem == '0) && (r_need != '0);
        end
    end

    assign o_result.valid       = r_o_valid;
    assign o_result.granted     = r_o_granted;
    assign o_result.chosen_slot = r_o_slot;
    assign o_result.remaining   = r_o_remaining;
    assign o_result.exact_fit   = r_o_exact;

endmodule
